// File: src/psc_pkg.sv
// psc_pkg: shared types and constants for the packet sequence checker
// with ring admission; no dependencies
package psc_pkg;

   localparam int unsigned RING_W     = 30;
   localparam int unsigned OFFSET_W   = 29;
   localparam int unsigned CNT_W      = 64;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [RING_W-1:0] RING_BYTES = 30'h2000_0000;

   localparam logic [15:0] RESET_DGRAM_LEN   = 16'd8230;
   localparam logic [31:0] RESET_PAYLOAD_LEN = 32'd8192;
   localparam logic [29:0] RESET_CHUNK_LIMIT = 30'd1048576;

   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DGRAM_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_LIMIT = 2'd2;

   typedef enum logic [1:0] {
      ST_STORED     = 2'd0,
      ST_BAD_LEN    = 2'd1,
      ST_RING_FULL  = 2'd2,
      ST_DRAIN_DONE = 2'd3
   } status_type;

   typedef struct packed {
      logic        cmd;
      logic [15:0] datagram_len;
      logic [63:0] seq_number;
      logic [31:0] header_payload_len;
      logic [29:0] drain_request;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic                       payload_len_bad;
      logic                       gap_seen;
      logic signed [63:0]         gap_delta;
      logic [OFFSET_W-1:0]        ring_offset;
      logic [RING_W-1:0]          first_part_len;
      logic [RING_W-1:0]          backlog;
      logic [CNT_W-1:0]           stored_packets;
      logic [CNT_W-1:0]           gap_events;
      logic [CNT_W-1:0]           missed_packets;
      logic [CNT_W-1:0]           ring_full_drops;
      logic [CNT_W-1:0]           bad_len_events;
   } rsp_type;

   typedef struct packed {
      logic [15:0] expected_datagram_len;
      logic [31:0] expected_payload_len;
      logic [29:0] drain_chunk_limit;
   } cfg_type;

   typedef struct packed {
      logic               len_ok;
      logic               payload_len_bad;
      logic               gap_seen;
      logic signed [63:0] gap_delta;
      logic [CNT_W-1:0]   gap_events;
      logic [CNT_W-1:0]   missed_packets;
      logic [CNT_W-1:0]   bad_len_events;
   } seq_result_type;

   typedef struct packed {
      status_type          status;
      logic [OFFSET_W-1:0] ring_offset;
      logic [RING_W-1:0]   first_part_len;
      logic [RING_W-1:0]   backlog;
      logic [CNT_W-1:0]    stored_packets;
      logic [CNT_W-1:0]    ring_full_drops;
   } ring_result_type;

endpackage

// File: src/psc_if.sv
// psc_if: valid/ready channel interfaces for request and response transactions
// depends on psc_pkg
interface psc_req_if;
   logic             valid;
   logic             ready;
   psc_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface psc_rsp_if;
   logic             valid;
   logic             ready;
   psc_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/psc_seq_check.sv
// psc_seq_check: datagram and payload length checks, sequence tracking and
// the gap, missed and bad-length counters; depends on psc_pkg
module psc_seq_check (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  psc_pkg::req_type        item,
   input  psc_pkg::cfg_type        cfg,
   output psc_pkg::seq_result_type result
);

   logic                           have_first_ff, have_first_in;
   logic [63:0]                    expected_seq_ff, expected_seq_in;
   logic [psc_pkg::CNT_W-1:0]      gap_count_ff, gap_count_in;
   logic [psc_pkg::CNT_W-1:0]      missed_count_ff, missed_count_in;
   logic [psc_pkg::CNT_W-1:0]      bad_len_count_ff, bad_len_count_in;
   logic                           is_packet;
   logic                           len_ok;
   logic                           good;
   logic                           gap;
   logic                           plen_bad;
   logic [63:0]                    delta;

   always_comb begin
      is_packet = (item.cmd == psc_pkg::CMD_PACKET);
      len_ok    = (item.datagram_len == cfg.expected_datagram_len);
      good      = is_packet && len_ok;
      gap       = good && have_first_ff && (item.seq_number != expected_seq_ff);
      delta     = gap ? (item.seq_number - expected_seq_ff) : 64'd0;
      plen_bad  = good && (item.header_payload_len != cfg.expected_payload_len);

      // a good packet always leaves the expected sequence one past its own
      have_first_in    = have_first_ff || good;
      expected_seq_in  = good ? (item.seq_number + 64'd1) : expected_seq_ff;
      gap_count_in     = gap_count_ff + {63'd0, gap};
      missed_count_in  = (gap && !delta[63]) ? (missed_count_ff + delta) : missed_count_ff;
      bad_len_count_in = bad_len_count_ff + {63'd0, (is_packet && !len_ok) || plen_bad};
   end

   always_comb begin
      result.len_ok          = len_ok;
      result.payload_len_bad = plen_bad;
      result.gap_seen        = gap;
      result.gap_delta       = delta;
      result.gap_events      = gap_count_in;
      result.missed_packets  = missed_count_in;
      result.bad_len_events  = bad_len_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff    <= 1'b0;
         expected_seq_ff  <= '0;
         gap_count_ff     <= '0;
         missed_count_ff  <= '0;
         bad_len_count_ff <= '0;
      end else if (advance) begin
         have_first_ff    <= have_first_in;
         expected_seq_ff  <= expected_seq_in;
         gap_count_ff     <= gap_count_in;
         missed_count_ff  <= missed_count_in;
         bad_len_count_ff <= bad_len_count_in;
      end
   end

endmodule

// File: src/psc_ring.sv
// psc_ring: ring admission for packets and grant clamping for drains,
// with head/tail offsets, backlog and stored/full-drop counters; depends on psc_pkg
module psc_ring (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  psc_pkg::req_type         item,
   input  logic                     len_ok,
   input  logic [29:0]              chunk_limit,
   output psc_pkg::ring_result_type result
);

   localparam int unsigned RW = psc_pkg::RING_W;
   localparam int unsigned OW = psc_pkg::OFFSET_W;

   logic [OW-1:0]             head_off_ff, head_off_in;
   logic [OW-1:0]             tail_off_ff, tail_off_in;
   logic [RW-1:0]             backlog_ff, backlog_in;
   logic [psc_pkg::CNT_W-1:0] stored_count_ff, stored_count_in;
   logic [psc_pkg::CNT_W-1:0] full_drop_count_ff, full_drop_count_in;

   logic          drain;
   logic [RW-1:0] len;
   logic [RW-1:0] room;
   logic [RW-1:0] head_to_wrap;
   logic [RW-1:0] tail_to_wrap;
   logic          admit;
   logic [RW-1:0] part;
   logic [RW-1:0] grant_a;
   logic [RW-1:0] grant_b;
   logic [RW-1:0] grant_c;
   logic [RW-1:0] grant;
   logic [RW-1:0] head_sum;
   logic [RW-1:0] tail_sum;

   always_comb begin
      drain        = (item.cmd == psc_pkg::CMD_DRAIN);
      len          = {{(RW-16){1'b0}}, item.datagram_len};
      room         = psc_pkg::RING_BYTES - backlog_ff;
      head_to_wrap = psc_pkg::RING_BYTES - {1'b0, head_off_ff};
      tail_to_wrap = psc_pkg::RING_BYTES - {1'b0, tail_off_ff};
      admit        = !drain && len_ok && (len <= room);
      part         = (len < head_to_wrap) ? len : head_to_wrap;

      grant_a = (backlog_ff < chunk_limit) ? backlog_ff : chunk_limit;
      grant_b = (grant_a < tail_to_wrap) ? grant_a : tail_to_wrap;
      grant_c = (grant_b < item.drain_request) ? grant_b : item.drain_request;
      grant   = drain ? grant_c : '0;

      head_sum = {1'b0, head_off_ff} + len;
      tail_sum = {1'b0, tail_off_ff} + grant;

      head_off_in        = admit ? head_sum[OW-1:0] : head_off_ff;
      tail_off_in        = tail_sum[OW-1:0];
      backlog_in         = admit ? (backlog_ff + len) : (backlog_ff - grant);
      stored_count_in    = stored_count_ff + {63'd0, admit};
      full_drop_count_in = full_drop_count_ff + {63'd0, !drain && len_ok && !admit};
   end

   always_comb begin
      result.backlog         = backlog_in;
      result.stored_packets  = stored_count_in;
      result.ring_full_drops = full_drop_count_in;
      result.ring_offset     = '0;
      result.first_part_len  = '0;
      if (drain) begin
         result.status         = psc_pkg::ST_DRAIN_DONE;
         result.ring_offset    = tail_off_ff;
         result.first_part_len = grant;
      end else if (!len_ok) begin
         result.status = psc_pkg::ST_BAD_LEN;
      end else if (!admit) begin
         result.status = psc_pkg::ST_RING_FULL;
      end else begin
         result.status         = psc_pkg::ST_STORED;
         result.ring_offset    = head_off_ff;
         result.first_part_len = part;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_off_ff        <= '0;
         tail_off_ff        <= '0;
         backlog_ff         <= '0;
         stored_count_ff    <= '0;
         full_drop_count_ff <= '0;
      end else if (advance) begin
         head_off_ff        <= head_off_in;
         tail_off_ff        <= tail_off_in;
         backlog_ff         <= backlog_in;
         stored_count_ff    <= stored_count_in;
         full_drop_count_ff <= full_drop_count_in;
      end
   end

endmodule

// File: src/packet_sequence_checker_ring_admit.sv
// packet_sequence_checker_ring_admit: top level with input register, csr
// registers and result register; depends on psc_pkg, psc_if, psc_seq_check, psc_ring
//
//   channel   direction  handshake           payload
//   req_chan  in         valid/ready         cmd, lengths, sequence, drain request
//   rsp_chan  out        valid/ready         status, gap info, ring offsets, counters
//   csr_*     in         csr_we, no ready    index 0..2, 32-bit write data
//
// one transaction per cycle sustained while rsp is not stalled
// the input register and the result register form a two-stage pipeline,
// checks and ring update done in one pass between them
// reset is synchronous, clears control state and counters and loads csr defaults
// a stalled rsp holds the result and backs up through the input register
module packet_sequence_checker_ring_admit (
   input  logic                              clock,
   input  logic                              reset,
   psc_req_if.sink                           req_chan,
   psc_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [psc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   psc_pkg::cfg_type         cfg_ff, cfg_in;
   logic                     a_valid_ff, a_valid_in;
   psc_pkg::req_type         a_item_ff, a_item_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   psc_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   logic                     accept;
   logic                     advance;
   psc_pkg::seq_result_type  seq_res;
   psc_pkg::ring_result_type ring_res;

   psc_seq_check u_seq_check (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (a_item_ff),
      .cfg     (cfg_ff),
      .result  (seq_res)
   );

   psc_ring u_ring (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (a_item_ff),
      .len_ok      (seq_res.len_ok),
      .chunk_limit (cfg_ff.drain_chunk_limit),
      .result      (ring_res)
   );

   always_comb begin
      advance        = a_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
      req_chan.ready = !a_valid_ff || advance;
      accept         = req_chan.valid && req_chan.ready;

      a_valid_in   = accept ? 1'b1 : (advance ? 1'b0 : a_valid_ff);
      a_item_in    = accept ? req_chan.data : a_item_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

      rsp_data_in                 = rsp_data_ff;
      if (advance) begin
         rsp_data_in.status          = ring_res.status;
         rsp_data_in.payload_len_bad = seq_res.payload_len_bad;
         rsp_data_in.gap_seen        = seq_res.gap_seen;
         rsp_data_in.gap_delta       = seq_res.gap_delta;
         rsp_data_in.ring_offset     = ring_res.ring_offset;
         rsp_data_in.first_part_len  = ring_res.first_part_len;
         rsp_data_in.backlog         = ring_res.backlog;
         rsp_data_in.stored_packets  = ring_res.stored_packets;
         rsp_data_in.gap_events      = seq_res.gap_events;
         rsp_data_in.missed_packets  = seq_res.missed_packets;
         rsp_data_in.ring_full_drops = ring_res.ring_full_drops;
         rsp_data_in.bad_len_events  = seq_res.bad_len_events;
      end

      rsp_chan.valid = rsp_valid_ff;
      rsp_chan.data  = rsp_data_ff;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            psc_pkg::CSR_DGRAM_LEN:   cfg_in.expected_datagram_len = csr_wdata[15:0];
            psc_pkg::CSR_PAYLOAD_LEN: cfg_in.expected_payload_len  = csr_wdata[31:0];
            psc_pkg::CSR_CHUNK_LIMIT: cfg_in.drain_chunk_limit     = csr_wdata[29:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_datagram_len <= psc_pkg::RESET_DGRAM_LEN;
         cfg_ff.expected_payload_len  <= psc_pkg::RESET_PAYLOAD_LEN;
         cfg_ff.drain_chunk_limit     <= psc_pkg::RESET_CHUNK_LIMIT;
         a_valid_ff                   <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff   <= a_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !advance |=> a_valid_ff)
      else $error("input register lost a transaction while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.backlog <= psc_pkg::RING_BYTES)
      else $error("backlog exceeds ring size");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == psc_pkg::ST_DRAIN_DONE
      |-> !rsp_data_ff.gap_seen && !rsp_data_ff.payload_len_bad
          && rsp_data_ff.gap_delta == 64'sd0)
      else $error("drain transaction carries packet check flags");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == psc_pkg::ST_BAD_LEN
      |-> rsp_data_ff.ring_offset == '0 && rsp_data_ff.first_part_len == '0
          && !rsp_data_ff.gap_seen)
      else $error("bad length drop carries ring or gap data");

   assert property (@(posedge clock) disable iff (reset)
      advance |-> (seq_res.gap_seen || seq_res.gap_delta == 64'sd0))
      else $error("gap delta without gap flag");

endmodule

// File: dv/psc_admit_monitor.sv
// psc_admit_monitor: watches the request, response and csr ports, predicts every
// response transaction of the sequence checker and compares it field by field
// depends on psc_pkg and psc_if
`timescale 1ns / 100ps

module psc_admit_monitor (
   input  logic                           clock,
   input  logic                           reset,
   psc_req_if                             req_chan,
   psc_rsp_if                             rsp_chan,
   input  logic                           csr_we,
   input  logic [psc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    failures,
   output int unsigned                    outstanding,
   output int unsigned                    seen_stored,
   output int unsigned                    seen_bad_len,
   output int unsigned                    seen_ring_full,
   output int unsigned                    seen_drains,
   output int unsigned                    seen_gaps
);

   localparam logic [63:0] RING_SPAN = {34'd0, psc_pkg::RING_BYTES};

   psc_pkg::cfg_type cfg;
   logic             seq_locked;
   logic [63:0]      next_seq;
   logic [63:0]      head_bytes;
   logic [63:0]      tail_bytes;
   logic [63:0]      stored_cnt;
   logic [63:0]      gap_cnt;
   logic [63:0]      missed_cnt;
   logic [63:0]      full_cnt;
   logic [63:0]      bad_len_cnt;
   psc_pkg::rsp_type awaited_rsp[$];

   int unsigned mismatch_total = 0;
   int unsigned n_stored       = 0;
   int unsigned n_bad_len      = 0;
   int unsigned n_ring_full    = 0;
   int unsigned n_drains       = 0;
   int unsigned n_gaps         = 0;

   function automatic logic [63:0] min64(input logic [63:0] a, input logic [63:0] b);
      return (a < b) ? a : b;
   endfunction

   // updates the ring and sequence state for one accepted transaction
   function automatic psc_pkg::rsp_type admit_or_drain(input psc_pkg::req_type t);
      psc_pkg::rsp_type r;
      logic [63:0]      used;
      logic [63:0]      off;
      logic [63:0]      grant;
      logic [63:0]      room;
      logic [63:0]      delta;
      r = '0;
      if (t.cmd == psc_pkg::CMD_DRAIN) begin
         used  = head_bytes - tail_bytes;
         off   = tail_bytes % RING_SPAN;
         grant = min64(used, {34'd0, cfg.drain_chunk_limit});
         grant = min64(grant, RING_SPAN - off);
         grant = min64(grant, {34'd0, t.drain_request});
         tail_bytes       = tail_bytes + grant;
         r.status         = psc_pkg::ST_DRAIN_DONE;
         r.ring_offset    = off[psc_pkg::OFFSET_W-1:0];
         r.first_part_len = grant[psc_pkg::RING_W-1:0];
      end else if (t.datagram_len != cfg.expected_datagram_len) begin
         bad_len_cnt = bad_len_cnt + 64'd1;
         r.status    = psc_pkg::ST_BAD_LEN;
      end else begin
         if (!seq_locked) begin
            next_seq   = t.seq_number;
            seq_locked = 1'b1;
         end
         if (t.seq_number != next_seq) begin
            delta       = t.seq_number - next_seq;
            gap_cnt     = gap_cnt + 64'd1;
            r.gap_seen  = 1'b1;
            r.gap_delta = delta;
            if (!delta[63]) begin
               missed_cnt = missed_cnt + delta;
            end
            next_seq = t.seq_number;
         end
         next_seq = next_seq + 64'd1;
         if (t.header_payload_len != cfg.expected_payload_len) begin
            bad_len_cnt       = bad_len_cnt + 64'd1;
            r.payload_len_bad = 1'b1;
         end
         used = head_bytes - tail_bytes;
         room = RING_SPAN - used;
         if (room < {48'd0, t.datagram_len}) begin
            full_cnt = full_cnt + 64'd1;
            r.status = psc_pkg::ST_RING_FULL;
         end else begin
            off              = head_bytes % RING_SPAN;
            grant            = min64({48'd0, t.datagram_len}, RING_SPAN - off);
            r.ring_offset    = off[psc_pkg::OFFSET_W-1:0];
            r.first_part_len = grant[psc_pkg::RING_W-1:0];
            head_bytes       = head_bytes + {48'd0, t.datagram_len};
            stored_cnt       = stored_cnt + 64'd1;
            r.status         = psc_pkg::ST_STORED;
         end
      end
      used              = head_bytes - tail_bytes;
      r.backlog         = used[psc_pkg::RING_W-1:0];
      r.stored_packets  = stored_cnt;
      r.gap_events      = gap_cnt;
      r.missed_packets  = missed_cnt;
      r.ring_full_drops = full_cnt;
      r.bad_len_events  = bad_len_cnt;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_total++;
      end
   endtask

   task automatic compare_rsp(input psc_pkg::rsp_type want, input psc_pkg::rsp_type got);
      check_field("status",          {62'd0, want.status},          {62'd0, got.status});
      check_field("payload_len_bad", {63'd0, want.payload_len_bad}, {63'd0, got.payload_len_bad});
      check_field("gap_seen",        {63'd0, want.gap_seen},        {63'd0, got.gap_seen});
      check_field("gap_delta",       want.gap_delta,                got.gap_delta);
      check_field("ring_offset",     {35'd0, want.ring_offset},     {35'd0, got.ring_offset});
      check_field("first_part_len",  {34'd0, want.first_part_len},  {34'd0, got.first_part_len});
      check_field("backlog",         {34'd0, want.backlog},         {34'd0, got.backlog});
      check_field("stored_packets",  want.stored_packets,           got.stored_packets);
      check_field("gap_events",      want.gap_events,               got.gap_events);
      check_field("missed_packets",  want.missed_packets,           got.missed_packets);
      check_field("ring_full_drops", want.ring_full_drops,          got.ring_full_drops);
      check_field("bad_len_events",  want.bad_len_events,           got.bad_len_events);
   endtask

   always @(posedge clock) begin : watch
      psc_pkg::rsp_type want;
      if (reset) begin
         cfg         = {psc_pkg::RESET_DGRAM_LEN, psc_pkg::RESET_PAYLOAD_LEN,
                        psc_pkg::RESET_CHUNK_LIMIT};
         seq_locked  = 1'b0;
         next_seq    = '0;
         head_bytes  = '0;
         tail_bytes  = '0;
         stored_cnt  = '0;
         gap_cnt     = '0;
         missed_cnt  = '0;
         full_cnt    = '0;
         bad_len_cnt = '0;
         awaited_rsp.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               psc_pkg::CSR_DGRAM_LEN:   cfg.expected_datagram_len = csr_wdata[15:0];
               psc_pkg::CSR_PAYLOAD_LEN: cfg.expected_payload_len  = csr_wdata;
               psc_pkg::CSR_CHUNK_LIMIT: cfg.drain_chunk_limit     = csr_wdata[29:0];
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response transaction with no prediction, expected none, actual %h",
                        $time, rsp_chan.data);
               mismatch_total++;
            end else begin
               want = awaited_rsp.pop_front();
               compare_rsp(want, rsp_chan.data);
               case (want.status)
                  psc_pkg::ST_STORED:    n_stored++;
                  psc_pkg::ST_BAD_LEN:   n_bad_len++;
                  psc_pkg::ST_RING_FULL: n_ring_full++;
                  default:               n_drains++;
               endcase
               if (want.gap_seen) begin
                  n_gaps++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            awaited_rsp.push_back(admit_or_drain(req_chan.data));
         end
      end
      failures       <= mismatch_total;
      outstanding    <= awaited_rsp.size();
      seen_stored    <= n_stored;
      seen_bad_len   <= n_bad_len;
      seen_ring_full <= n_ring_full;
      seen_drains    <= n_drains;
      seen_gaps      <= n_gaps;
   end

endmodule

// File: dv/packet_sequence_checker_ring_admit_tb.sv
// packet_sequence_checker_ring_admit_tb: drives packet and drain transactions
// through several csr settings and handshake pressure modes, gives the verdict
// depends on psc_pkg, psc_if, the block and psc_admit_monitor
`timescale 1ns / 100ps

module packet_sequence_checker_ring_admit_tb;

   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned FILL_PACKETS = 40;
   localparam int unsigned PHASE_ITEMS  = 160;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psc_req_if req_chan();
   psc_rsp_if rsp_chan();

   logic                           csr_we;
   logic [psc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [psc_pkg::CSR_DATA_W-1:0] csr_wdata;

   int unsigned failures;
   int unsigned outstanding;
   int unsigned seen_stored;
   int unsigned seen_bad_len;
   int unsigned seen_ring_full;
   int unsigned seen_drains;
   int unsigned seen_gaps;

   int unsigned      sender_idle_pct = 0;
   int unsigned      sink_stall_pct  = 0;
   int unsigned      quiet_cycles    = 0;
   psc_pkg::cfg_type cur_cfg;
   logic [63:0]      gen_seq;

   always #5 clock = ~clock;

   packet_sequence_checker_ring_admit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   psc_admit_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .failures       (failures),
      .outstanding    (outstanding),
      .seen_stored    (seen_stored),
      .seen_bad_len   (seen_bad_len),
      .seen_ring_full (seen_ring_full),
      .seen_drains    (seen_drains),
      .seen_gaps      (seen_gaps)
   );

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic psc_pkg::req_type packet_item(input logic [15:0] len,
                                                    input logic [63:0] seq,
                                                    input logic [31:0] plen);
      psc_pkg::req_type t;
      logic [31:0]      junk;
      junk                 = $urandom;
      t.cmd                = psc_pkg::CMD_PACKET;
      t.datagram_len       = len;
      t.seq_number         = seq;
      t.header_payload_len = plen;
      t.drain_request      = junk[29:0];
      return t;
   endfunction

   function automatic psc_pkg::req_type drain_item(input logic [29:0] request);
      psc_pkg::req_type t;
      logic [31:0]      junk;
      junk                 = $urandom;
      t.cmd                = psc_pkg::CMD_DRAIN;
      t.datagram_len       = junk[15:0];
      t.seq_number         = {$urandom, $urandom};
      t.header_payload_len = $urandom;
      t.drain_request      = request;
      return t;
   endfunction

   // mostly well-formed packet streams, some gaps, wrong lengths and drains
   function automatic psc_pkg::req_type next_random_item();
      int unsigned pick;
      logic [31:0] bits;
      logic [15:0] len;
      logic [63:0] seq;
      logic [31:0] plen;
      pick = $urandom_range(99);
      if (pick < 30) begin
         case ($urandom_range(9))
            0:       bits = 32'd0;
            1:       bits = {2'd0, psc_pkg::RING_BYTES};
            2:       bits = $urandom_range(0, 32'h2000_0000);
            default: bits = $urandom_range(0, 200000);
         endcase
         return drain_item(bits[29:0]);
      end
      len = cur_cfg.expected_datagram_len;
      if ($urandom_range(99) < 12) begin
         bits = $urandom;
         len  = bits[15:0];
      end
      pick = $urandom_range(99);
      if (pick < 82) begin
         seq = gen_seq;
      end else if (pick < 90) begin
         seq = gen_seq + 64'($urandom_range(1, 20));
      end else if (pick < 95) begin
         seq = gen_seq - 64'($urandom_range(1, 20));
      end else begin
         seq = {$urandom, $urandom};
      end
      if (len == cur_cfg.expected_datagram_len) begin
         gen_seq = seq + 64'd1;
      end
      plen = ($urandom_range(99) < 88) ? cur_cfg.expected_payload_len : 32'($urandom);
      return packet_item(len, seq, plen);
   endfunction

   task automatic send_item(input psc_pkg::req_type item);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= item;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic load_settings(input logic [15:0] len, input logic [31:0] plen,
                                input logic [29:0] chunk);
      logic [31:0] junk;
      junk = $urandom;
      wait_quiet();
      csr_we    <= 1'b1;
      csr_index <= psc_pkg::CSR_DGRAM_LEN;
      csr_wdata <= {junk[31:16], len};
      @(negedge clock);
      csr_index <= psc_pkg::CSR_PAYLOAD_LEN;
      csr_wdata <= plen;
      @(negedge clock);
      csr_index <= psc_pkg::CSR_CHUNK_LIMIT;
      csr_wdata <= {junk[1:0], chunk};
      @(negedge clock);
      csr_we <= 1'b0;
      cur_cfg = {len, plen, chunk};
   endtask

   initial begin
      logic [15:0] dlen;
      logic [31:0] bits;
      logic [31:0] plen;
      logic [29:0] chunk;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      csr_we         = 1'b0;
      csr_index      = psc_pkg::CSR_DGRAM_LEN;
      csr_wdata      = '0;
      cur_cfg        = {psc_pkg::RESET_DGRAM_LEN, psc_pkg::RESET_PAYLOAD_LEN,
                        psc_pkg::RESET_CHUNK_LIMIT};
      dlen           = psc_pkg::RESET_DGRAM_LEN;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: empty ring, length extremes, sequence wrap and gap extremes
      send_item(drain_item(30'd100));
      send_item(packet_item(16'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
      send_item(packet_item(16'hFFFF, 64'd0, 32'd0));
      send_item(packet_item(dlen, 64'hFFFF_FFFF_FFFF_FFFE, psc_pkg::RESET_PAYLOAD_LEN));
      send_item(packet_item(dlen, 64'hFFFF_FFFF_FFFF_FFFF, psc_pkg::RESET_PAYLOAD_LEN));
      send_item(packet_item(dlen, 64'd0, psc_pkg::RESET_PAYLOAD_LEN));
      send_item(packet_item(dlen, 64'd10, psc_pkg::RESET_PAYLOAD_LEN));
      send_item(packet_item(dlen, 64'd3, 32'd0));
      send_item(packet_item(dlen, 64'd4, 32'hFFFF_FFFF));
      send_item(packet_item(dlen, 64'h8000_0000_0000_0005, psc_pkg::RESET_PAYLOAD_LEN));
      send_item(packet_item(dlen, 64'd5, psc_pkg::RESET_PAYLOAD_LEN));
      send_item(drain_item(30'd0));
      send_item(drain_item(psc_pkg::RING_BYTES));
      send_item(packet_item(dlen, 64'd6, psc_pkg::RESET_PAYLOAD_LEN));
      send_item(packet_item(dlen, 64'd7, psc_pkg::RESET_PAYLOAD_LEN));
      send_item(drain_item(30'd1));
      send_item(drain_item(30'h1FFF_FFFF));
      load_settings(dlen, psc_pkg::RESET_PAYLOAD_LEN, 30'd0);
      send_item(packet_item(dlen, 64'd8, psc_pkg::RESET_PAYLOAD_LEN));
      send_item(drain_item(psc_pkg::RING_BYTES));
      load_settings(16'd0, 32'd0, 30'd1);
      send_item(packet_item(16'd0, 64'd9, 32'd0));
      send_item(drain_item(30'd5));

      // a burst of largest datagrams into the ring, then empty it
      load_settings(16'hFFFF, 32'hFFFF_FFFF, psc_pkg::RING_BYTES);
      gen_seq = 64'd10;
      for (int i = 0; i < FILL_PACKETS; i++) begin
         plen    = ($urandom_range(99) < 90) ? 32'hFFFF_FFFF : 32'($urandom);
         send_item(packet_item(16'hFFFF, gen_seq, plen));
         gen_seq = gen_seq + 64'd1;
      end
      send_item(packet_item(16'hFFFF, gen_seq + 64'd7, 32'd1));
      send_item(packet_item(16'hFFFF, gen_seq, 32'hFFFF_FFFF));
      for (int i = 0; i < 4; i++) begin
         send_item(drain_item(psc_pkg::RING_BYTES));
      end
      gen_seq = gen_seq + 64'd1;

      for (int k = 0; k < 8; k++) begin
         case (k)
            0:       load_settings(psc_pkg::RESET_DGRAM_LEN, psc_pkg::RESET_PAYLOAD_LEN,
                                   psc_pkg::RESET_CHUNK_LIMIT);
            1:       load_settings(16'd0, 32'd0, 30'd1);
            2:       load_settings(16'hFFFF, 32'hFFFF_FFFF, psc_pkg::RING_BYTES);
            default: begin
               bits  = $urandom;
               dlen  = (k % 2 == 1) ? bits[15:0] : {4'd0, bits[11:0]};
               plen  = $urandom;
               bits  = (k % 2 == 1) ? $urandom_range(1, 32'h2000_0000)
                                    : $urandom_range(1, 70000);
               chunk = bits[29:0];
               load_settings(dlen, plen, chunk);
            end
         endcase
         case (k % 4)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 58; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 58; end
            default: begin sender_idle_pct = 12; sink_stall_pct = 12; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_item(next_random_item());
         end
      end

      wait_quiet();
      repeat (10) @(negedge clock);
      $display("Checked %0d stored, %0d bad-length, %0d ring-full and %0d drain transactions,",
               seen_stored, seen_bad_len, seen_ring_full, seen_drains);
      $display("with %0d sequence gaps, over 11 csr settings and 4 handshake pressure modes",
               seen_gaps);
      if (failures == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
